@@ sv/fosa_pkg.sv @@
package fosa_pkg;

	localparam int OCC_W   = 32;
	localparam int MODE_W  = 5;
	localparam int COUNT_W = 6;

	// Upper bound on the mode count; the occupation word caps it as well.
	localparam int MAX_MODES = 32;
	localparam int EFF_MODES = (MAX_MODES < OCC_W) ? MAX_MODES : OCC_W;

	localparam logic [COUNT_W-1:0] MODE_COUNT_RST = COUNT_W'(32);
	localparam logic [COUNT_W-1:0] MODE_COUNT_MAX = COUNT_W'(EFF_MODES);

	typedef logic [OCC_W-1:0]   occ_t;
	typedef logic [MODE_W-1:0]  mode_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef enum logic {
		CMD_ONE_BODY = 1'b0,
		CMD_TWO_BODY = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t  cmd;
		occ_t  occupation;
		mode_t create_outer;
		mode_t create_inner;
		mode_t annihilate_first;
		mode_t annihilate_second;
	} in_item_t;

	typedef struct packed {
		occ_t new_occupation;
		logic allowed;
		logic sign_negative;
	} out_item_t;

	// Outcome of one ladder step: success and the parity of the modes before it.
	typedef struct packed {
		logic ok;
		logic par;
	} step_t;

endpackage

@@ sv/fosa_ifs.sv @@
interface fosa_in_if;
	logic               valid;
	logic               ready;
	fosa_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fosa_out_if;
	logic                valid;
	logic                ready;
	fosa_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fosa_cfg_if;
	logic             valid;
	logic             ready;
	fosa_pkg::count_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/fosa_ladder.sv @@
module fosa_ladder (
	input  fosa_pkg::occ_t  st_in,
	input  fosa_pkg::occ_t  used,
	input  fosa_pkg::mode_t pos,
	input  logic            create,
	output fosa_pkg::occ_t  st_out,
	output fosa_pkg::step_t res
);

	fosa_pkg::occ_t bit_m;
	fosa_pkg::occ_t below_incl;
	fosa_pkg::occ_t above;

	// Lower modes sit at higher bit positions, so the sign counts the bits above.
	// At the top position the shift wraps to zero and the mask becomes all ones.
	assign bit_m      = fosa_pkg::occ_t'(1) << pos;
	assign below_incl = (bit_m << 1) - fosa_pkg::occ_t'(1);
	assign above      = used & ~below_incl;

	assign res.ok  = ((st_in & bit_m) != '0) != create;
	assign res.par = ^(st_in & above);
	assign st_out  = create ? (st_in | bit_m) : (st_in & ~bit_m);

endmodule

@@ sv/fosa_apply.sv @@
module fosa_apply (
	input  fosa_pkg::in_item_t  item,
	input  fosa_pkg::count_t    mode_count,
	output fosa_pkg::out_item_t result
);

	fosa_pkg::count_t        n_eff;
	logic [fosa_pkg::OCC_W:0] used_wide;
	fosa_pkg::occ_t          used;
	logic                    two;
	logic                    in_range;
	fosa_pkg::count_t        pos_r, pos_s, pos_q, pos_p;
	fosa_pkg::occ_t          st_r, st_s, st_q, st_p, st_pin;
	fosa_pkg::step_t         res_r, res_s, res_q, res_p;
	logic                    ok;
	logic                    sign;

	assign n_eff = (mode_count > fosa_pkg::MODE_COUNT_MAX) ? fosa_pkg::MODE_COUNT_MAX
		: mode_count;
	assign used_wide = ({{fosa_pkg::OCC_W{1'b0}}, 1'b1} << n_eff) - 1'b1;
	assign used      = used_wide[fosa_pkg::OCC_W-1:0];
	assign two       = (item.cmd == fosa_pkg::CMD_TWO_BODY);

	assign in_range = ({1'b0, item.create_outer} < n_eff)
		&& ({1'b0, item.annihilate_first} < n_eff)
		&& (!two || (({1'b0, item.create_inner} < n_eff)
			&& ({1'b0, item.annihilate_second} < n_eff)));

	// Mode k lives at bit n - 1 - k; out-of-range positions are masked by in_range.
	assign pos_r = n_eff - 1'b1 - {1'b0, item.annihilate_first};
	assign pos_s = n_eff - 1'b1 - {1'b0, item.annihilate_second};
	assign pos_q = n_eff - 1'b1 - {1'b0, item.create_inner};
	assign pos_p = n_eff - 1'b1 - {1'b0, item.create_outer};

	fosa_ladder u_step_r (
		.st_in (item.occupation),
		.used  (used),
		.pos   (pos_r[fosa_pkg::MODE_W-1:0]),
		.create(1'b0),
		.st_out(st_r),
		.res   (res_r)
	);

	fosa_ladder u_step_s (
		.st_in (st_r),
		.used  (used),
		.pos   (pos_s[fosa_pkg::MODE_W-1:0]),
		.create(1'b0),
		.st_out(st_s),
		.res   (res_s)
	);

	fosa_ladder u_step_q (
		.st_in (st_s),
		.used  (used),
		.pos   (pos_q[fosa_pkg::MODE_W-1:0]),
		.create(1'b1),
		.st_out(st_q),
		.res   (res_q)
	);

	// A one-body command skips the two middle steps.
	assign st_pin = two ? st_q : st_r;

	fosa_ladder u_step_p (
		.st_in (st_pin),
		.used  (used),
		.pos   (pos_p[fosa_pkg::MODE_W-1:0]),
		.create(1'b1),
		.st_out(st_p),
		.res   (res_p)
	);

	always_comb begin
		ok   = in_range && res_r.ok && res_p.ok;
		sign = res_r.par ^ res_p.par;
		if (two) begin
			ok   = ok && res_s.ok && res_q.ok;
			sign = sign ^ res_s.par ^ res_q.par;
		end
		result.allowed        = ok;
		result.sign_negative  = ok & sign;
		result.new_occupation = ok ? st_p : '0;
	end

endmodule

@@ sv/fermion_operator_sign_apply_unit.sv @@
// Channel | Modport | Payload                          | Transfer when
// req     | sink    | cmd, occupation, four mode fields | req.valid && req.ready
// rsp     | source  | new_occupation, allowed, sign     | rsp.valid && rsp.ready
// cfg     | sink    | mode_count (6 bits)               | cfg.valid && cfg.ready
//
// One item per cycle sustained while rsp is ready; an item is held in the input register,
// and its result from the four-step ladder chain is held in the result register and offered
// on rsp. A stalled result keeps its register and the input register still takes one more
// item. Reset clears both valid flags and sets mode_count to 32; cfg is always ready.
module fermion_operator_sign_apply_unit (
	input logic          clk,
	input logic          arst_n,
	fosa_in_if.sink      req,
	fosa_out_if.source   rsp,
	fosa_cfg_if.sink     cfg
);

	fosa_pkg::count_t    mode_count_q;
	fosa_pkg::in_item_t  item_s1;
	logic                vld_s1;
	fosa_pkg::out_item_t res_s2;
	logic                vld_s2;
	fosa_pkg::out_item_t res_comb;
	logic                adv_s2;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_count_q <= fosa_pkg::MODE_COUNT_RST;
		end else if (cfg.valid) begin
			mode_count_q <= cfg.data;
		end
	end

	assign adv_s2    = !vld_s2 || rsp.ready;
	assign req.ready = !vld_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				vld_s1 <= req.valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.data;
		end
		if (adv_s2 && vld_s1) begin
			res_s2 <= res_comb;
		end
	end

	fosa_apply u_apply (
		.item      (item_s1),
		.mode_count(mode_count_q),
		.result    (res_comb)
	);

	assign rsp.valid = vld_s2;
	assign rsp.data  = res_s2;

	// A refused result carries no state and no sign.
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !res_s2.allowed) |-> (res_s2.new_occupation == '0 && !res_s2.sign_negative))
		else $error("refused result with non-zero payload");

	// Input back-pressure only arises when both stages are full and the output stalls.
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (vld_s1 && vld_s2 && !rsp.ready))
		else $error("input stalled without a full pipeline");

	// An item taken in occupies the first stage in the next cycle.
	a_fill_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> vld_s1)
		else $error("accepted item lost before the first stage");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int HOLD_OFF_LEN  = 80;
	localparam int PHASE_ITEMS   = 132;
	localparam int RANDOM_PHASES = 11;

	logic clk;
	logic arst_n;

	fosa_in_if  req_ch ();
	fosa_out_if rsp_ch ();
	fosa_cfg_if cfg_ch ();

	fermion_operator_sign_apply_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	fosa_pkg::in_item_t  excitation_queue[$];
	fosa_pkg::out_item_t predicted_outcomes[$];
	fosa_pkg::count_t    model_mode_count = fosa_pkg::MODE_COUNT_RST;
	bit          req_took = 0;
	bit          sender_gaps = 1;
	int unsigned gap_left = 0;
	int unsigned burst_left = 0;
	bit          hold_off_request = 0;
	int unsigned hold_off_left = 0;
	int unsigned stall_level = 4;
	int unsigned ready_run = 0;
	bit          ready_level = 1;
	int unsigned fail_count = 0;
	int unsigned results_seen = 0;
	int unsigned allowed_seen = 0;
	int unsigned negative_seen = 0;
	int unsigned one_body_sent = 0;
	int unsigned two_body_sent = 0;
	int unsigned settings_used = 0;
	int unsigned cycle_count = 0;
	fosa_pkg::out_item_t got_outcome;
	fosa_pkg::out_item_t want_outcome;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies the ladder operators in order: annihilations first, creations last.
	// Each step adds the parity of the occupied modes with a lower index.
	function automatic fosa_pkg::out_item_t apply_excitation(fosa_pkg::in_item_t it,
		fosa_pkg::count_t mc);
		fosa_pkg::out_item_t res;
		int unsigned n;
		int unsigned mode_seq[4];
		bit          create_seq[4];
		int unsigned steps;
		logic [63:0] st;
		logic [63:0] used;
		logic [63:0] bitm;
		logic [63:0] above;
		bit          ok;
		bit          sign;
		bit          occ;
		n = (32'(mc) > fosa_pkg::EFF_MODES) ? fosa_pkg::EFF_MODES : 32'(mc);
		st = {32'b0, it.occupation};
		sign = 1'b0;
		mode_seq[0] = 32'(it.annihilate_first);
		create_seq[0] = 1'b0;
		ok = (32'(it.create_outer) < n) && (32'(it.annihilate_first) < n);
		if (it.cmd == fosa_pkg::CMD_TWO_BODY) begin
			mode_seq[1] = 32'(it.annihilate_second);
			create_seq[1] = 1'b0;
			mode_seq[2] = 32'(it.create_inner);
			create_seq[2] = 1'b1;
			mode_seq[3] = 32'(it.create_outer);
			create_seq[3] = 1'b1;
			steps = 4;
			ok = ok && (32'(it.create_inner) < n) && (32'(it.annihilate_second) < n);
		end else begin
			mode_seq[1] = 32'(it.create_outer);
			create_seq[1] = 1'b1;
			steps = 2;
		end
		used = (64'd1 << n) - 64'd1;
		for (int k = 0; k < steps; k++) begin
			if (ok) begin
				bitm = 64'd1 << (n - 1 - mode_seq[k]);
				above = used & ~((bitm << 1) - 64'd1);
				occ = |(st & bitm);
				if (occ == create_seq[k]) begin
					ok = 1'b0;
				end else begin
					sign ^= ^(st & above);
					st = create_seq[k] ? (st | bitm) : (st & ~bitm);
				end
			end
		end
		res.new_occupation = ok ? st[31:0] : '0;
		res.allowed = ok;
		res.sign_negative = ok & sign;
		return res;
	endfunction

	function automatic fosa_pkg::occ_t mode_bit(int unsigned mode, int unsigned n);
		return fosa_pkg::occ_t'(64'd1 << (n - 1 - mode));
	endfunction

	// Mostly legal excitations with random content; the rest is unconstrained noise,
	// which also covers modes out of range and failing steps.
	function automatic fosa_pkg::in_item_t make_excitation(int unsigned n);
		fosa_pkg::in_item_t it;
		int unsigned r;
		int unsigned s;
		int unsigned q;
		int unsigned p;
		bit          two;
		fosa_pkg::occ_t occ;
		it.cmd = fosa_pkg::cmd_t'($urandom_range(1));
		it.occupation = $urandom;
		it.create_outer = fosa_pkg::mode_t'($urandom);
		it.create_inner = fosa_pkg::mode_t'($urandom);
		it.annihilate_first = fosa_pkg::mode_t'($urandom);
		it.annihilate_second = fosa_pkg::mode_t'($urandom);
		if (n == 0 || $urandom_range(99) < 25)
			return it;
		two = (it.cmd == fosa_pkg::CMD_TWO_BODY);
		r = $urandom_range(n - 1);
		s = r;
		if (n > 1 && $urandom_range(15) != 0) begin
			while (s == r)
				s = $urandom_range(n - 1);
		end
		q = $urandom_range(n - 1);
		p = $urandom_range(n - 1);
		occ = it.occupation | mode_bit(r, n);
		if (two)
			occ |= mode_bit(s, n);
		if (two && q != r && q != s)
			occ &= ~mode_bit(q, n);
		if (p != r && !(two && p == s))
			occ &= ~mode_bit(p, n);
		it.occupation = occ;
		it.annihilate_first = fosa_pkg::mode_t'(r);
		it.create_outer = fosa_pkg::mode_t'(p);
		if (two) begin
			it.annihilate_second = fosa_pkg::mode_t'(s);
			it.create_inner = fosa_pkg::mode_t'(q);
		end
		return it;
	endfunction

	task automatic push_excitation(fosa_pkg::cmd_t c, fosa_pkg::occ_t occ,
		int p, int q, int r, int s);
		fosa_pkg::in_item_t it;
		it.cmd = c;
		it.occupation = occ;
		it.create_outer = fosa_pkg::mode_t'(p);
		it.create_inner = fosa_pkg::mode_t'(q);
		it.annihilate_first = fosa_pkg::mode_t'(r);
		it.annihilate_second = fosa_pkg::mode_t'(s);
		excitation_queue.push_back(it);
	endtask

	task automatic write_mode_count(fosa_pkg::count_t value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	// Holds the stimulus back until every outstanding result has come out.
	// The check runs at the rising edge, where the queue and the valid line are settled.
	task automatic wait_idle();
		while (excitation_queue.size() != 0 || req_ch.valid
			|| predicted_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Sender: bursts of random length separated by random gaps while sender_gaps is set.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (req_ch.valid && !req_took) begin
			req_ch.valid <= 1'b1;
		end else begin
			req_took = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				req_ch.valid <= 1'b0;
			end else if (excitation_queue.size() > 0) begin
				req_ch.data <= excitation_queue.pop_front();
				req_ch.valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = sender_gaps ? $urandom_range(0, 6) : 0;
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: alternating runs of ready and stall, plus the occasional long hold-off.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_off_request) begin
			hold_off_request = 1'b0;
			hold_off_left = HOLD_OFF_LEN;
			rsp_ch.ready <= 1'b0;
		end else if (hold_off_left > 0) begin
			hold_off_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			if (stall_level == 0) begin
				ready_level = 1'b1;
			end else if (ready_run > 0) begin
				ready_run--;
			end else begin
				ready_level = !ready_level;
				ready_run = ready_level ? $urandom_range(1, 16) : $urandom_range(0, stall_level);
			end
			rsp_ch.ready <= ready_level;
		end
	end

	// Monitor: predicts on every input transfer and checks every output transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				model_mode_count = cfg_ch.data;
			if (req_ch.valid && req_ch.ready) begin
				predicted_outcomes.push_back(apply_excitation(req_ch.data, model_mode_count));
				req_took = 1'b1;
				if (req_ch.data.cmd == fosa_pkg::CMD_TWO_BODY)
					two_body_sent++;
				else
					one_body_sent++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_outcome = rsp_ch.data;
				results_seen++;
				if (predicted_outcomes.size() == 0) begin
					$error("result with nothing outstanding: occupation %h",
						got_outcome.new_occupation);
					fail_count++;
				end else begin
					want_outcome = predicted_outcomes.pop_front();
					if (got_outcome.new_occupation !== want_outcome.new_occupation) begin
						$error("new_occupation: expected %h, got %h",
							want_outcome.new_occupation, got_outcome.new_occupation);
						fail_count++;
					end
					if (got_outcome.allowed !== want_outcome.allowed) begin
						$error("allowed: expected %b, got %b",
							want_outcome.allowed, got_outcome.allowed);
						fail_count++;
					end
					if (got_outcome.sign_negative !== want_outcome.sign_negative) begin
						$error("sign_negative: expected %b, got %b",
							want_outcome.sign_negative, got_outcome.sign_negative);
						fail_count++;
					end
					if (want_outcome.allowed)
						allowed_seen++;
					if (want_outcome.sign_negative)
						negative_seen++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", cycle_count);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int unsigned phase_counts[RANDOM_PHASES];
		int unsigned mc;
		int unsigned n;
		phase_counts = '{1, 2, 32, 63, 0, 17, 33, 31, 5, 32, 0};
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Full width: empty and full states, the end modes, and each way a step can fail.
		write_mode_count(fosa_pkg::count_t'(32));
		push_excitation(fosa_pkg::CMD_ONE_BODY, 32'h0000_0000, 0, 0, 0, 0);
		push_excitation(fosa_pkg::CMD_ONE_BODY, 32'hFFFF_FFFF, 31, 31, 31, 31);
		push_excitation(fosa_pkg::CMD_ONE_BODY, 32'h8000_0000, 31, 0, 0, 0);
		push_excitation(fosa_pkg::CMD_ONE_BODY, 32'h0000_0001, 0, 17, 31, 3);
		push_excitation(fosa_pkg::CMD_ONE_BODY, 32'hFFFF_FFFF, 5, 0, 0, 0);
		push_excitation(fosa_pkg::CMD_TWO_BODY, 32'hC000_0000, 31, 30, 0, 1);
		push_excitation(fosa_pkg::CMD_TWO_BODY, 32'h5555_5555, 0, 2, 31, 29);
		push_excitation(fosa_pkg::CMD_TWO_BODY, 32'hFFFF_FFFF, 3, 4, 7, 7);
		push_excitation(fosa_pkg::CMD_TWO_BODY, 32'h0F00_0000, 20, 20, 4, 5);
		push_excitation(fosa_pkg::CMD_TWO_BODY, 32'h0F00_0000, 6, 4, 4, 5);
		push_excitation(fosa_pkg::CMD_TWO_BODY, 32'h0000_0000, 1, 2, 3, 4);
		wait_idle();

		// Four modes: indices past the top, ignored one-body fields, and high bits passing through.
		write_mode_count(fosa_pkg::count_t'(4));
		push_excitation(fosa_pkg::CMD_ONE_BODY, 32'h0000_000F, 4, 0, 0, 0);
		push_excitation(fosa_pkg::CMD_TWO_BODY, 32'h0000_000C, 3, 2, 0, 7);
		push_excitation(fosa_pkg::CMD_ONE_BODY, 32'hFFFF_FFF8, 0, 31, 0, 31);
		push_excitation(fosa_pkg::CMD_ONE_BODY, 32'hABCD_0008, 3, 31, 0, 31);
		push_excitation(fosa_pkg::CMD_TWO_BODY, 32'hFFFF_FFF5, 3, 1, 0, 2);
		wait_idle();

		// A zero count rejects everything; counts past the word width are capped.
		write_mode_count(fosa_pkg::count_t'(0));
		push_excitation(fosa_pkg::CMD_ONE_BODY, 32'hFFFF_FFFF, 0, 0, 0, 0);
		push_excitation(fosa_pkg::CMD_TWO_BODY, 32'h0000_0000, 0, 0, 0, 0);
		wait_idle();
		write_mode_count(fosa_pkg::count_t'(63));
		push_excitation(fosa_pkg::CMD_ONE_BODY, 32'hFFFF_FFFF, 31, 0, 31, 0);
		push_excitation(fosa_pkg::CMD_TWO_BODY, 32'h0000_0003, 0, 1, 31, 30);
		wait_idle();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			mc = (ph == RANDOM_PHASES - 1) ? $urandom_range(63) : phase_counts[ph];
			write_mode_count(fosa_pkg::count_t'(mc));
			n = (mc > fosa_pkg::EFF_MODES) ? fosa_pkg::EFF_MODES : mc;
			sender_gaps = (ph % 3 != 2);
			stall_level = (ph % 4 == 3 || ph == 8) ? 0 : $urandom_range(1, 12);
			// Output held off while the sender streams with no gaps, so the input backs up.
			if (ph == 2) begin
				sender_gaps = 1'b0;
				hold_off_request = 1'b1;
			end
			repeat (PHASE_ITEMS) excitation_queue.push_back(make_excitation(n));
		end

		wait_idle();
		repeat (6) @(negedge clk);
		if (predicted_outcomes.size() != 0) begin
			$error("results outstanding at the end: expected 0, got %0d",
				predicted_outcomes.size());
			fail_count++;
		end
		$display("Checked %0d results (%0d one-body, %0d two-body items) over %0d mode counts.",
			results_seen, one_body_sent, two_body_sent, settings_used);
		$display("Of these %0d were allowed and %0d carried a minus sign; %0d mismatches.",
			allowed_seen, negative_seen, fail_count);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
